// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the ZIP entry extractor.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SZEE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define SZEE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/szee_pkg.sv -----
// ---------------------------------------------------------------------------
// szee_pkg
// Types, constants and helpers shared by the stored ZIP entry extractor.
// ---------------------------------------------------------------------------
package szee_pkg;

    localparam int MAX_NAME_CHARS_DEF = 16;
    localparam int NAME_IDX_W         = 4;    // 16 characters per configured name
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [31:0] LOCAL_HDR_SIG = 32'h504B0304;
    localparam int HEADER_BYTES  = 30;
    localparam int SIG_BYTES     = 4;
    localparam int SIZE_AT       = 18;
    localparam int NAME_LEN_AT   = 26;
    localparam int EXTRA_LEN_AT  = 28;

    typedef enum logic [4:0] {
        PH_SCAN    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_NAME    = 5'b00100,
        PH_EXTRA   = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        REG_FIRST_NAME_LOW     = 3'd0,
        REG_FIRST_NAME_HIGH    = 3'd1,
        REG_FIRST_NAME_LENGTH  = 3'd2,
        REG_SECOND_NAME_LOW    = 3'd3,
        REG_SECOND_NAME_HIGH   = 3'd4,
        REG_SECOND_NAME_LENGTH = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
        logic [4:0]  length;
    } name_cfg_t;

    typedef struct packed {
        name_cfg_t first;
        name_cfg_t second;
    } names_cfg_t;

    typedef struct packed {
        logic        entry_last;
        logic [31:0] payload_offset;
        logic        target;
        logic [7:0]  payload_byte;
    } result_t;

    // Character idx of a configured name, character 0 in the low byte of low.
    function automatic logic [7:0] name_char(input name_cfg_t nc,
                                             input logic [NAME_IDX_W-1:0] idx);
        logic [127:0] chars;
        chars = {nc.high, nc.low};
        return chars[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ----- rtl/szee_parser.sv -----
// ---------------------------------------------------------------------------
// szee_parser
// Front end: signature scan, local header decode, name compare and payload
// classification. Produces at most one result per accepted byte.
// ---------------------------------------------------------------------------
module szee_parser import szee_pkg::*; #(
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    input  names_cfg_t cfg,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [4:0]  MAX_LEN   = 5'(MAX_NAME_CHARS);
    localparam logic [31:0] MAX_INDEX = 32'(MAX_NAME_CHARS);

    phase_t      phase_reg, phase_next;
    logic [23:0] window_reg, window_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] size_reg, size_next;
    logic [15:0] name_len_reg, name_len_next;
    logic [15:0] extra_len_reg, extra_len_next;
    logic [1:0]  flags_reg, flags_next;

    // State as seen by this byte, after the clear that a start byte causes.
    phase_t      cur_phase;
    logic [23:0] cur_window;
    logic [31:0] cur_count;
    logic [31:0] cur_size;
    logic [15:0] cur_name_len;
    logic [15:0] cur_extra_len;
    logic [1:0]  cur_flags;

    logic [31:0] count_inc;
    logic [31:0] sig_word;
    logic        pay_last;
    logic        emit;

    function automatic logic len_ok(input logic [4:0] len, input logic [15:0] nl);
        return (len != 5'd0) && (len <= MAX_LEN) && ({11'd0, len} == nl);
    endfunction

    always_comb begin
        cur_phase     = in_start ? PH_SCAN : phase_reg;
        cur_window    = in_start ? 24'd0 : window_reg;
        cur_count     = in_start ? 32'd0 : count_reg;
        cur_size      = in_start ? 32'd0 : size_reg;
        cur_name_len  = in_start ? 16'd0 : name_len_reg;
        cur_extra_len = in_start ? 16'd0 : extra_len_reg;
        cur_flags     = in_start ? 2'b11 : flags_reg;
    end

    assign count_inc = cur_count + 32'd1;
    assign sig_word  = {cur_window, in_byte};
    assign pay_last  = ({1'b0, cur_count} + 33'd1) >= {1'b0, cur_size};

    always_comb begin
        phase_next     = cur_phase;
        window_next    = cur_window;
        count_next     = cur_count;
        size_next      = cur_size;
        name_len_next  = cur_name_len;
        extra_len_next = cur_extra_len;
        flags_next     = cur_flags;
        emit           = 1'b0;

        case (cur_phase)
            PH_HEADER: begin
                case (cur_count)
                    SIZE_AT:          size_next[7:0]       = in_byte;
                    SIZE_AT + 1:      size_next[15:8]      = in_byte;
                    SIZE_AT + 2:      size_next[23:16]     = in_byte;
                    SIZE_AT + 3:      size_next[31:24]     = in_byte;
                    NAME_LEN_AT:      name_len_next[7:0]   = in_byte;
                    NAME_LEN_AT + 1:  name_len_next[15:8]  = in_byte;
                    EXTRA_LEN_AT:     extra_len_next[7:0]  = in_byte;
                    EXTRA_LEN_AT + 1: extra_len_next[15:8] = in_byte;
                    default: ;
                endcase
                count_next = count_inc;
                if (count_inc >= 32'(HEADER_BYTES)) begin
                    flags_next = {len_ok(cfg.second.length, name_len_next),
                                  len_ok(cfg.first.length, name_len_next)};
                    count_next = 32'd0;
                    if (name_len_next != 16'd0) begin
                        phase_next = PH_NAME;
                    end else if (extra_len_next != 16'd0) begin
                        phase_next = PH_EXTRA;
                    end else if (size_next != 32'd0) begin
                        phase_next = PH_PAYLOAD;
                    end else begin
                        phase_next  = PH_SCAN;
                        window_next = 24'd0;
                    end
                end
            end

            PH_NAME: begin
                if (cur_count >= MAX_INDEX) begin
                    flags_next = 2'b00;
                end else begin
                    if (name_char(cfg.first, cur_count[NAME_IDX_W-1:0]) != in_byte) begin
                        flags_next[0] = 1'b0;
                    end
                    if (name_char(cfg.second, cur_count[NAME_IDX_W-1:0]) != in_byte) begin
                        flags_next[1] = 1'b0;
                    end
                end
                count_next = count_inc;
                if (count_inc >= {16'd0, cur_name_len}) begin
                    count_next = 32'd0;
                    if (cur_extra_len != 16'd0) begin
                        phase_next = PH_EXTRA;
                    end else if (cur_size != 32'd0) begin
                        phase_next = PH_PAYLOAD;
                    end else begin
                        phase_next  = PH_SCAN;
                        window_next = 24'd0;
                    end
                end
            end

            PH_EXTRA: begin
                count_next = count_inc;
                if (count_inc >= {16'd0, cur_extra_len}) begin
                    count_next = 32'd0;
                    if (cur_size != 32'd0) begin
                        phase_next = PH_PAYLOAD;
                    end else begin
                        phase_next  = PH_SCAN;
                        window_next = 24'd0;
                    end
                end
            end

            PH_PAYLOAD: begin
                emit = (cur_flags != 2'b00);
                if (pay_last) begin
                    phase_next  = PH_SCAN;
                    window_next = 24'd0;
                    count_next  = 32'd0;
                end else begin
                    count_next = count_inc;
                end
            end

            default: begin
                if (sig_word == LOCAL_HDR_SIG) begin
                    phase_next     = PH_HEADER;
                    count_next     = 32'(SIG_BYTES);
                    size_next      = 32'd0;
                    name_len_next  = 16'd0;
                    extra_len_next = 16'd0;
                    window_next    = 24'd0;
                end else begin
                    phase_next  = PH_SCAN;
                    window_next = sig_word[23:0];
                end
            end
        endcase
    end

    assign res_valid          = in_fire & emit;
    assign res.payload_byte   = in_byte;
    assign res.target         = ~cur_flags[0];
    assign res.payload_offset = cur_count;
    assign res.entry_last     = pay_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SCAN;
            window_reg    <= 24'd0;
            count_reg     <= 32'd0;
            size_reg      <= 32'd0;
            name_len_reg  <= 16'd0;
            extra_len_reg <= 16'd0;
            flags_reg     <= 2'b11;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            window_reg    <= window_next;
            count_reg     <= count_next;
            size_reg      <= size_next;
            name_len_reg  <= name_len_next;
            extra_len_reg <= extra_len_next;
            flags_reg     <= flags_next;
        end
    end

endmodule

// ----- rtl/szee_queue.sv -----
// ---------------------------------------------------------------------------
// szee_queue
// Short first-in first-out queue of results between front and back end.
// ---------------------------------------------------------------------------
module szee_queue import szee_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    pop_valid,
    output result_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    result_t            slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slots_reg[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = pop & pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/szee_out.sv -----
// ---------------------------------------------------------------------------
// szee_out
// Back end: drains the queue into the registered result channel.
// ---------------------------------------------------------------------------
module szee_out import szee_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  result_t     q_data,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    // The output register refills in the same cycle that it is emptied.
    assign load       = q_valid & (~valid_reg | m_tready);
    assign q_pop      = load;
    assign valid_next = load | (valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.payload_offset, data_reg.payload_byte};
    assign m_tuser  = data_reg.target;
    assign m_tlast  = data_reg.entry_last;

endmodule

// ----- rtl/stored_zip_entry_extractor_top.sv -----
// ---------------------------------------------------------------------------
// stored_zip_entry_extractor_top
// Extracts the content of up to two named entries from a stored ZIP stream.
// ---------------------------------------------------------------------------
// Usage:
// The s_ channel takes one archive byte per transaction in s_tdata; s_tuser
// marks the first byte of a new archive and clears the parser before that
// byte is parsed. Each content byte of an entry whose name equals one of the
// two configured names leaves on the m_ channel: m_tdata carries the byte and
// its offset inside the entry, m_tuser tells which name matched (the first
// wins when both do), m_tlast flags the entry's final byte.
// Names are written on the cfg_ channel; the user must do so only while the
// block is idle, which the block itself does not enforce. Throughput is one
// byte per cycle while s_tready is high: the parser updates its header
// counter and compares one name character per byte. A result shows on
// m_tvalid after its byte is taken: it is written into the result queue and
// then loads into the output register, from which the receiver accepts it.
// Reset (aresetn low at a clock edge) clears the parser, the queue, the
// output register and all name registers.
// When the receiver stalls, results collect in the two-entry queue while the
// output register holds its transaction; s_tready falls only once the queue
// is full, so bytes that produce no result also wait then.
// ---------------------------------------------------------------------------
module stored_zip_entry_extractor_top import szee_pkg::*; #(
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Archive byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] archive_byte
    input  logic        s_tuser,    // [0] archive_start
    // Extracted content stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] payload_byte, [39:8] payload_offset
    output logic        m_tuser,    // [0] target
    output logic        m_tlast,    // entry_last
    // Register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    names_cfg_t names_reg;
    logic       in_fire;
    logic       cfg_fire;
    logic       res_valid;
    result_t    res;
    logic       q_full;
    logic       q_valid;
    result_t    q_data;
    logic       q_pop;

    // Registers are accepted every cycle.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            names_reg <= '0;
        end else if (cfg_fire) begin
            case (cfg_reg_t'(cfg_index))
                REG_FIRST_NAME_LOW:     names_reg.first.low     <= cfg_data;
                REG_FIRST_NAME_HIGH:    names_reg.first.high    <= cfg_data;
                REG_FIRST_NAME_LENGTH:  names_reg.first.length  <= cfg_data[4:0];
                REG_SECOND_NAME_LOW:    names_reg.second.low    <= cfg_data;
                REG_SECOND_NAME_HIGH:   names_reg.second.high   <= cfg_data;
                REG_SECOND_NAME_LENGTH: names_reg.second.length <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // A byte is taken whenever the queue can absorb a possible result.
    assign s_tready = ~q_full;
    assign in_fire  = s_tvalid & s_tready;

    szee_parser #(
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .cfg       (names_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    szee_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    szee_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/szee_checker.sv -----
// ---------------------------------------------------------------------------
// szee_checker
// Port-level checks for the stored ZIP entry extractor, bound to its top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module szee_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result transaction stays offered.
    `SZEE_ASSERT(a_out_valid_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")

    // A stalled result transaction keeps its payload.
    `SZEE_ASSERT(a_out_data_holds, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // Reset empties the output register and the result queue.
    `SZEE_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid && s_tready, "reset left results pending")

    // The input only stalls when results are backed up behind the output register.
    `SZEE_ASSERT(a_stall_has_cause, aclk, aresetn, !s_tready |-> m_tvalid, "input stalled with empty output")

endmodule

bind stored_zip_entry_extractor_top szee_checker u_szee_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
